// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Types, S-box tables and GF(2^8) helpers shared by the cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned StoreDepth = 4 * (NumRounds + 1);
  localparam int unsigned RkAddrW = 6;

  typedef enum logic [0:0] {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
    logic [7:0] r;
    begin
      case (a)
        8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
        8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
        8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
        8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
        8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
        8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
        8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
        8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
        8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
        8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
        8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
        8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
        8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
        8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
        8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
        8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
        8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
        8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
        8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
        8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
        8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
        8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
        8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
        8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
        8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
        8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
        8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
        8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
        8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
        8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
        8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
        8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
        8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
        8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
        8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
        8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
        8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
        8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
        8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
        8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
        8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
        8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
        8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
        8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
        8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
        8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
        8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
        8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
        8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
        8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
        8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
        8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
        8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
        8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
        8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
        8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
        8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
        8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
        8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
        8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
        8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
        8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
        8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
        8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] a);
    logic [7:0] r;
    begin
      case (a)
        8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
        8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
        8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
        8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
        8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
        8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
        8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
        8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
        8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
        8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
        8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
        8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
        8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
        8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
        8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
        8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
        8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
        8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
        8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
        8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
        8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
        8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
        8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
        8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
        8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
        8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
        8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
        8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
        8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
        8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
        8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
        8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
        8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
        8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
        8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
        8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
        8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
        8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
        8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
        8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
        8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
        8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
        8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
        8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
        8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
        8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
        8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
        8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
        8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
        8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
        8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
        8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
        8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
        8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
        8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
        8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
        8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
        8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
        8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
        8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
        8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
        8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
        8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
        8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // forward column mix, byte 0 in bits 31:24
  function automatic logic [31:0] mix_fwd(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    begin
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    end
  endfunction

  // inverse mix as pre-multiply by {04,05} then forward mix
  function automatic logic [31:0] mix_inv(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    begin
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      return mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round unit
// One forward or inverse round on the 128-bit state, shared by every round.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round
  import aes_pkg::*;
(
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] round_key,
  input  wire logic         inverse,
  input  wire logic         skip_mix,
  output logic      [127:0] state_out
);

  logic [127:0] sub, shf, mixd, keyed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub[127-8*i -: 8] = inverse ? sbox_inv(state_in[127-8*i -: 8])
                                  : sbox_fwd(state_in[127-8*i -: 8]);
    end
    // byte 4c+r; forward takes column c+r, inverse places into c+r
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          shf[127-8*(4*((c+r)%4)+r) -: 8] = sub[127-8*(4*c+r) -: 8];
        end else begin
          shf[127-8*(4*c+r) -: 8] = sub[127-8*(4*((c+r)%4)+r) -: 8];
        end
      end
    end
    keyed = shf ^ (inverse ? round_key : 128'h0);
    for (int c = 0; c < 4; c++) begin
      if (inverse) begin
        mixd[127-32*c -: 32] = mix_inv(keyed[127-32*c -: 32]);
      end else begin
        mixd[127-32*c -: 32] = mix_fwd(shf[127-32*c -: 32]);
      end
    end
    if (inverse) begin
      state_out = skip_mix ? keyed : mixd;
    end else begin
      state_out = (skip_mix ? shf : mixd) ^ round_key;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Iterative FIPS-197 engine: one round a cycle through one shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   Load the key with cfg_we/cfg_index/cfg_data (index 0 key_high, index 1
//   key_low) while the block is idle. Present a word on in_word with start
//   high; it is taken when busy is low. One result word appears on out_word
//   with done high for exactly one cycle; the receiver cannot stall it.
// Timing:
//   After a key change the first word waits for key expansion, one
//   round-key word a cycle from the S-box unit. Then a load state with
//   the first key add, the ten rounds in the round state (one round each
//   through the round unit, the round key read as four words from the key
//   store) and the output state: done is high in the output state, busy
//   drops after it, and a new word is taken only once busy is low again.
//   Decryption runs the inverse cipher with the same timing.
// Reset:
//   rst clears the keys to zero and marks the key schedule stale; the store
//   itself is not cleared and is always rewritten before use.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher
  import aes_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  in_word,
  output logic           busy,
  output logic           done,
  output out_item_t      out_word,
  input  wire logic      cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [63:0] cfg_data
);

  state_t       state, state_next;
  logic [63:0]  key_high, key_low;
  logic         keys_expanded;
  logic         inverse;
  logic [3:0]   rnd;
  logic [RkAddrW-1:0] wcnt;
  logic [127:0] blk;
  logic [7:0]   rcon;
  logic [127:0] last4;        // four most recent schedule words

  // key store: four word banks so all four words of a round key read together
  logic [31:0]  rk_mem0 [NumRounds+1];
  logic [31:0]  rk_mem1 [NumRounds+1];
  logic [31:0]  rk_mem2 [NumRounds+1];
  logic [31:0]  rk_mem3 [NumRounds+1];
  logic [127:0] rk_q;
  logic [3:0]   rk_raddr;

  logic [31:0]  t_word, new_word;
  logic [127:0] round_out;
  logic [3:0]   wrow;

  assign wrow = wcnt[5:2];

  always_comb begin
    t_word = last4[31:0];
    if (wcnt[1:0] == 2'd0) begin
      t_word = {sbox_fwd(t_word[23:16]), sbox_fwd(t_word[15:8]),
                sbox_fwd(t_word[7:0]),  sbox_fwd(t_word[31:24])}
               ^ {rcon, 24'h0};
    end
    new_word = last4[127:96] ^ t_word;
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) begin
      unique case (wcnt[1:0])
        2'd0: rk_mem0[wrow] <= new_word;
        2'd1: rk_mem1[wrow] <= new_word;
        2'd2: rk_mem2[wrow] <= new_word;
        default: rk_mem3[wrow] <= new_word;
      endcase
    end else if (state == ST_IDLE && start && !keys_expanded) begin
      rk_mem0[0] <= key_high[63:32];
      rk_mem1[0] <= key_high[31:0];
      rk_mem2[0] <= key_low[63:32];
      rk_mem3[0] <= key_low[31:0];
    end
    // last schedule word is still being written when the decrypt key is read
    rk_q <= {rk_mem0[rk_raddr], rk_mem1[rk_raddr], rk_mem2[rk_raddr],
             (state == ST_EXPAND && wcnt[1:0] == 2'd3 && wrow == rk_raddr)
               ? new_word : rk_mem3[rk_raddr]};
  end

  aes_round u_round (
    .state_in  (blk),
    .round_key (rk_q),
    .inverse   (inverse),
    .skip_mix  (rnd == 4'(NumRounds)),
    .state_out (round_out)
  );

  // read address follows state_next, so the registered round key is ready when used
  always_comb begin
    rk_raddr = 4'd0;
    unique case (state_next)
      ST_LOAD:  rk_raddr = (state == ST_IDLE ? in_word.opcode == OP_DECRYPT : inverse)
                           ? 4'(NumRounds) : 4'd0;
      ST_ROUND: rk_raddr = inverse ? 4'(NumRounds) - (rnd + 4'd1)
                                   : rnd + 4'd1;
      default:  rk_raddr = 4'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = keys_expanded ? ST_LOAD : ST_EXPAND;
      ST_EXPAND: if (wcnt == 6'(StoreDepth - 1)) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (rnd == 4'(NumRounds)) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      key_high      <= '0;
      key_low       <= '0;
      keys_expanded <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        keys_expanded <= 1'b0;
        unique case (reg_index_t'(cfg_index))
          REG_KEY_HIGH: key_high <= cfg_data;
          default:      key_low  <= cfg_data;
        endcase
      end else if (state == ST_EXPAND && state_next == ST_LOAD) begin
        keys_expanded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          inverse <= in_word.opcode == OP_DECRYPT;
          blk     <= {in_word.block_high, in_word.block_low};
          wcnt    <= 6'd4;
          rcon    <= 8'h01;
          last4   <= {key_high, key_low};
          rnd     <= 4'd0;
        end
      end
      ST_EXPAND: begin
        wcnt  <= wcnt + 6'd1;
        last4 <= {last4[95:0], new_word};
        if (wcnt[1:0] == 2'd0) rcon <= xtime(rcon);
      end
      ST_LOAD: begin
        blk <= blk ^ rk_q;
        rnd <= 4'd1;
      end
      ST_ROUND: begin
        blk <= round_out;
        rnd <= rnd + 4'd1;
      end
      default: ;
    endcase
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;
  assign out_word.result_high = blk[127:64];
  assign out_word.result_low  = blk[63:0];

endmodule

`default_nettype wire
